// ===== sv/seven_segment_scan_driver_assert.svh =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Concurrent assertion forms for the scan driver controller.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver package
// Types, codes, constants and small helper functions shared by the driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

    // Number of display digits (4 to 16)
    localparam int DIGITS = 8;
    localparam int IDX_W  = $clog2(DIGITS);

    // Command opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_RAW       = 3'd1;
    localparam logic [2:0] OP_INT       = 3'd2;
    localparam logic [2:0] OP_INT_DOT   = 3'd3;
    localparam logic [2:0] OP_TIME      = 3'd4;
    localparam logic [2:0] OP_BLINK_ON  = 3'd5;
    localparam logic [2:0] OP_BLINK_OFF = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMMON_ANODE = 2'd0;
    localparam logic [1:0] CFG_ON_TIME      = 2'd1;
    localparam logic [1:0] CFG_BLINK_PERIOD = 2'd2;
    localparam logic [1:0] CFG_FULL_HOUR    = 2'd3;

    // Scan phases
    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_DRIVE = 2'd1;
    localparam logic [1:0] PH_LIT   = 2'd2;

    localparam logic [7:0]  SEG_DOT     = 8'h80;
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  digit_index;
        logic [31:0] value;
        logic [3:0]  dot_position;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
    } t_in_item;

    typedef struct packed {
        logic [7:0] segment_lines;
        logic [3:0] digit_select;
        logic       digit_active;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIGIT,
        S_BLANK,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec_simple;
        logic conv_init;
        logic mul;
        logic digit_write;
        logic blank_step;
    } t_cmd;

    typedef struct packed {
        logic is_convert;
        logic conv_last;
        logic blank_stop;
    } t_status;

    // Active-high segment pattern of a decimal digit
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] f;
        case (d)
            4'd0:    f = 8'h3F;
            4'd1:    f = 8'h06;
            4'd2:    f = 8'h5B;
            4'd3:    f = 8'h4F;
            4'd4:    f = 8'h66;
            4'd5:    f = 8'h6D;
            4'd6:    f = 8'h7D;
            4'd7:    f = 8'h27;
            4'd8:    f = 8'h7F;
            4'd9:    f = 8'h6F;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    function automatic logic [6:0] clamp99(input logic [6:0] v);
        return (v > 7'd99) ? 7'd99 : v;
    endfunction

    // Tens of a value up to 99 by reciprocal multiply (205 / 2048)
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] t10;
        t10 = 7'(tens_of(v)) * 7'd10;
        return 4'(v - t10);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver controller
// Sequences each transaction: load, execute or convert and blank, report.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_scan_driver_assert.svh"

module ssd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ssd_pkg::t_status i_status,
    output ssd_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    ssd_pkg::t_state r_state;
    ssd_pkg::t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequence and issue commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ssd_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ssd_pkg::S_EXEC;
                end
            end
            ssd_pkg::S_EXEC: begin
                if (i_status.is_convert) begin
                    o_cmd.conv_init = 1'b1;
                    n_state         = ssd_pkg::S_MUL;
                end else begin
                    o_cmd.exec_simple = 1'b1;
                    n_state           = ssd_pkg::S_REPORT;
                end
            end
            ssd_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ssd_pkg::S_DIGIT;
            end
            ssd_pkg::S_DIGIT: begin
                o_cmd.digit_write = 1'b1;
                n_state = i_status.conv_last ? ssd_pkg::S_BLANK : ssd_pkg::S_MUL;
            end
            ssd_pkg::S_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_status.blank_stop) begin
                    n_state = ssd_pkg::S_REPORT;
                end
            end
            ssd_pkg::S_REPORT: begin
                n_state = ssd_pkg::S_IDLE;
            end
            default: begin
                n_state = ssd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ssd_pkg::S_IDLE);
    assign o_done = (r_state == ssd_pkg::S_REPORT);

    `SSD_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_start && !o_busy, r_state == ssd_pkg::S_EXEC, "accepted transaction did not enter execute")
    `SSD_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done && !o_busy, "result strobe not followed by idle")
    `SSD_ASSERT_NEXT(a_mul_digit, i_clk, i_rst_n, r_state == ssd_pkg::S_MUL, r_state == ssd_pkg::S_DIGIT, "product not followed by digit write")
    `SSD_ASSERT_NEXT(a_last_blank, i_clk, i_rst_n, (r_state == ssd_pkg::S_DIGIT) && i_status.conv_last, r_state == ssd_pkg::S_BLANK, "last digit not followed by blanking pass")

endmodule

`default_nettype wire

// ===== sv/ssd_datapath.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver datapath
// Pattern store, blink state, scan timing, decimal conversion and config.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssd_pkg::t_cmd     i_cmd,
    input  wire ssd_pkg::t_in_item i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_wdata,
    output ssd_pkg::t_status       o_status,
    output ssd_pkg::t_out_item     o_result
);

    localparam int IW = ssd_pkg::IDX_W;
    localparam int ND = ssd_pkg::DIGITS;

    // Configuration
    logic        r_common_anode;
    logic [15:0] r_on_time;
    logic [7:0]  r_blink_period;
    logic        r_full_hour;

    // Display state
    logic [7:0]    r_pattern [ND];
    logic [7:0]    n_pattern [ND];
    logic [ND-1:0] r_blink_on, n_blink_on;
    logic [ND-1:0] r_dark, n_dark;
    logic [3:0]    r_scan_digit, n_scan_digit;
    logic [15:0]   r_elapsed, n_elapsed;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_blink_cnt, n_blink_cnt;
    logic [7:0]    r_drv_segs, n_drv_segs;
    logic [3:0]    r_drv_sel, n_drv_sel;
    logic          r_drv_act, n_drv_act;

    // Conversion state
    ssd_pkg::t_in_item r_item;
    logic [31:0]       r_val;
    logic [63:0]       r_prod;
    logic [IW-1:0]     r_k, n_k;
    logic [ND-1:0]     r_zero, n_zero;
    logic              r_dot_en;

    // Combinational helpers
    logic [15:0]   elapsed_inc;
    logic          on_expired;
    logic [1:0]    phase_eff;
    logic [3:0]    scan_sel;
    logic [7:0]    blink_inc;
    logic [ND-1:0] dark_scan;
    logic [28:0]   quot;
    logic [31:0]   quot_x10;
    logic [3:0]    rem;
    logic [6:0]    hh, mm, ss;
    logic [3:0]    hh_tens;
    logic          idx_ok;
    logic          dot_ok;
    logic [7:0]    raw_segs;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_anode <= 1'b0;
            r_on_time      <= 16'd2;
            r_blink_period <= 8'd100;
            r_full_hour    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssd_pkg::CFG_COMMON_ANODE: r_common_anode <= i_cfg_wdata[0];
                ssd_pkg::CFG_ON_TIME:      r_on_time      <= i_cfg_wdata;
                ssd_pkg::CFG_BLINK_PERIOD: r_blink_period <= i_cfg_wdata[7:0];
                ssd_pkg::CFG_FULL_HOUR:    r_full_hour    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Latch the transaction and run the reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.conv_init) begin
            r_val <= r_item.value;
        end else if (i_cmd.digit_write) begin
            r_val <= {3'b000, quot};
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_val) * 64'(ssd_pkg::RECIP_10);
        end
    end

    // Split off one decimal digit
    assign quot     = r_prod[63:ssd_pkg::RECIP_SHIFT];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = 4'(r_val - quot_x10);

    // Time fields
    assign hh      = ssd_pkg::clamp99(r_item.hours);
    assign mm      = ssd_pkg::clamp99(r_item.minutes);
    assign ss      = ssd_pkg::clamp99(r_item.seconds);
    assign hh_tens = ssd_pkg::tens_of(hh);

    assign idx_ok   = (int'(r_item.digit_index) < ND);
    assign dot_ok   = (r_item.dot_position != 4'd0) && (int'(r_item.dot_position) < ND);
    assign raw_segs = r_common_anode ? ~r_item.value[7:0] : r_item.value[7:0];

    // Scan step helpers
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign on_expired  = (elapsed_inc >= r_on_time);
    assign phase_eff   = on_expired ? ssd_pkg::PH_BLANK : r_phase;
    assign scan_sel    = (int'(r_scan_digit) >= ND) ? 4'd0 : r_scan_digit;
    assign blink_inc   = r_blink_cnt + 8'd1;
    assign dark_scan   = (blink_inc >= r_blink_period) ? (r_dark ^ r_blink_on) : r_dark;

    // Next state of store, blink, scan and conversion
    always_comb begin
        n_pattern    = r_pattern;
        n_blink_on   = r_blink_on;
        n_dark       = r_dark;
        n_scan_digit = r_scan_digit;
        n_elapsed    = r_elapsed;
        n_phase      = r_phase;
        n_blink_cnt  = r_blink_cnt;
        n_drv_segs   = r_drv_segs;
        n_drv_sel    = r_drv_sel;
        n_drv_act    = r_drv_act;
        n_k          = r_k;
        n_zero       = r_zero;

        if (i_cmd.exec_simple) begin
            case (r_item.opcode)
                ssd_pkg::OP_TICK: begin
                    if (on_expired) begin
                        n_drv_segs = 8'h00;
                        n_drv_sel  = 4'd0;
                        n_drv_act  = 1'b0;
                    end
                    case (phase_eff)
                        ssd_pkg::PH_BLANK: begin
                            n_phase   = ssd_pkg::PH_DRIVE;
                            n_elapsed = 16'd0;
                        end
                        ssd_pkg::PH_DRIVE: begin
                            n_phase     = ssd_pkg::PH_LIT;
                            n_elapsed   = 16'd0;
                            n_dark      = dark_scan;
                            n_blink_cnt = (blink_inc >= r_blink_period) ? 8'd0 : blink_inc;
                            n_drv_segs  = dark_scan[scan_sel[IW-1:0]] ?
                                          8'h00 : r_pattern[scan_sel[IW-1:0]];
                            n_drv_sel   = scan_sel;
                            n_drv_act   = 1'b1;
                            n_scan_digit = scan_sel + 4'd1;
                        end
                        default: begin
                            n_phase   = phase_eff;
                            n_elapsed = elapsed_inc;
                        end
                    endcase
                end
                ssd_pkg::OP_RAW: begin
                    if (idx_ok) begin
                        n_pattern[r_item.digit_index[IW-1:0]] = raw_segs;
                    end
                end
                ssd_pkg::OP_TIME: begin
                    n_pattern[0] = (hh_tens == 4'd0 && !r_full_hour) ?
                                   8'h00 : ssd_pkg::seg_font(hh_tens);
                    n_pattern[1] = ssd_pkg::seg_font(ssd_pkg::ones_of(hh));
                    n_pattern[2] = ssd_pkg::seg_font(ssd_pkg::tens_of(mm));
                    n_pattern[3] = ssd_pkg::seg_font(ssd_pkg::ones_of(mm));
                    if (ND >= 6) begin
                        n_pattern[IW'(4 % ND)] = ssd_pkg::seg_font(ssd_pkg::tens_of(ss));
                        n_pattern[IW'(5 % ND)] = ssd_pkg::seg_font(ssd_pkg::ones_of(ss));
                    end
                end
                ssd_pkg::OP_BLINK_ON: begin
                    if (idx_ok) begin
                        n_blink_on[r_item.digit_index[IW-1:0]] = 1'b1;
                        n_dark[r_item.digit_index[IW-1:0]]     = 1'b1;
                    end
                end
                ssd_pkg::OP_BLINK_OFF: begin
                    if (idx_ok) begin
                        n_blink_on[r_item.digit_index[IW-1:0]] = 1'b0;
                        n_dark[r_item.digit_index[IW-1:0]]     = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // Start conversion at the rightmost digit
        if (i_cmd.conv_init) begin
            n_k = IW'(ND - 1);
        end

        // Write one digit, dot included, and note whether it is zero
        if (i_cmd.digit_write) begin
            n_pattern[r_k] = ssd_pkg::seg_font(rem) |
                             ((r_dot_en && r_item.dot_position == 4'(r_k)) ?
                              ssd_pkg::SEG_DOT : 8'h00);
            n_zero[r_k]    = (rem == 4'd0);
            n_k            = (r_k == '0) ? r_k : r_k - IW'(1);
        end

        // Drop leading zeros from the left, keeping the dot
        if (i_cmd.blank_step) begin
            if (r_zero[r_k]) begin
                n_pattern[r_k] = (r_dot_en && r_item.dot_position == 4'(r_k)) ?
                                 ssd_pkg::SEG_DOT : 8'h00;
            end
            n_k = r_k + IW'(1);
        end
    end

    // Hold display and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ND; i++) begin
                r_pattern[i] <= 8'h00;
            end
            r_blink_on   <= '0;
            r_dark       <= '0;
            r_scan_digit <= 4'd0;
            r_elapsed    <= 16'd0;
            r_phase      <= ssd_pkg::PH_BLANK;
            r_blink_cnt  <= 8'd0;
            r_drv_segs   <= 8'h00;
            r_drv_sel    <= 4'd0;
            r_drv_act    <= 1'b0;
            r_k          <= '0;
            r_zero       <= '0;
            r_dot_en     <= 1'b0;
        end else begin
            r_pattern    <= n_pattern;
            r_blink_on   <= n_blink_on;
            r_dark       <= n_dark;
            r_scan_digit <= n_scan_digit;
            r_elapsed    <= n_elapsed;
            r_phase      <= n_phase;
            r_blink_cnt  <= n_blink_cnt;
            r_drv_segs   <= n_drv_segs;
            r_drv_sel    <= n_drv_sel;
            r_drv_act    <= n_drv_act;
            r_k          <= n_k;
            r_zero       <= n_zero;
            if (i_cmd.conv_init) begin
                r_dot_en <= (r_item.opcode == ssd_pkg::OP_INT_DOT);
            end
        end
    end

    // Report status to the controller
    assign o_status.is_convert = (r_item.opcode == ssd_pkg::OP_INT) ||
                                 ((r_item.opcode == ssd_pkg::OP_INT_DOT) && dot_ok);
    assign o_status.conv_last  = (r_k == '0);
    assign o_status.blank_stop = !r_zero[r_k] || (r_k == IW'(ND - 2));

    // Drive the result in the configured polarity
    assign o_result.segment_lines = r_common_anode ? ~r_drv_segs : r_drv_segs;
    assign o_result.digit_select  = r_drv_sel;
    assign o_result.digit_active  = r_drv_act;

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Multiplexed seven-segment display driver with blink and decimal display.
// ----------------------------------------------------------------------------
//   channel   handshake                payload
//   command   i_start, o_busy          i_item   (ssd_pkg::t_in_item)
//   result    o_done strobe            o_result (ssd_pkg::t_out_item)
//   config    i_cfg_we                 i_cfg_index, i_cfg_wdata
//
// A tick, raw write, time or blink transaction runs through the execute and
// report states after accept; its result strobes in the report state.
// Integer transactions run from the rightmost digit: the shared reciprocal
// multiplier yields one digit per multiply and write state pair, then the
// leading zero pass clears one digit a cycle. Every transaction gives one result.
// Synchronous active-low reset; the receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_driver (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire ssd_pkg::t_in_item i_item,
    output logic                   o_done,
    output ssd_pkg::t_out_item     o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_wdata
);

    ssd_pkg::t_cmd    cmd;
    ssd_pkg::t_status status;

    // Sequence transactions
    ssd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    // Store, scan and convert
    ssd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== verif/seven_segment_scan_driver_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment scan driver testbench
// Sends display commands and millisecond ticks through the start/busy port.
// A behavioural model of the pattern store, blink state and scan sequencer
// predicts the drive state after every command. Each strobed result is
// compared field by field with the oldest prediction. Runs cover reset
// defaults, the register extremes and random settings, with random idling.
// ----------------------------------------------------------------------------

module seven_segment_scan_driver_tb;

    import ssd_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int PRINT_LIMIT = 60;

    // Active-high font for decimal digits
    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_item;
    logic        o_done;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    // Display model state
    logic [7:0]  pattern_mem [DIGITS];
    bit          blink_en [DIGITS];
    bit          blink_dark [DIGITS];
    logic [3:0]  scan_ptr;
    logic [15:0] lit_ms;
    logic [1:0]  scan_state;
    logic [7:0]  blink_count;
    logic [12:0] drive_word;

    // Model copy of the registers
    bit          anode_mode;
    logic [15:0] on_time;
    logic [7:0]  blink_period;
    bit          full_hour;

    t_out_item   expected_drive_q [$];
    int          mismatch_count;
    int          idle_mode;

    seven_segment_scan_driver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Display model
    // ------------------------------------------------------------------------

    function automatic void model_reset();
        for (int k = 0; k < DIGITS; k++) begin
            pattern_mem[k] = 8'h00;
            blink_en[k]    = 1'b0;
            blink_dark[k]  = 1'b0;
        end
        scan_ptr     = '0;
        lit_ms       = '0;
        scan_state   = PH_BLANK;
        blink_count  = '0;
        drive_word   = '0;
        anode_mode   = 1'b0;
        on_time      = 16'd2;
        blink_period = 8'd100;
        full_hour    = 1'b0;
    endfunction

    // Decimal conversion, blanking leading zeros but keeping the last digit
    function automatic void load_decimal(input logic [31:0] v);
        logic [31:0] rest;
        rest = v;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            pattern_mem[k] = DIGIT_FONT[4'(rest % 10)];
            rest = rest / 10;
        end
        for (int k = 0; k < DIGITS - 1; k++) begin
            if (pattern_mem[k] != DIGIT_FONT[0])
                break;
            pattern_mem[k] = 8'h00;
        end
    endfunction

    // Advance blink timing and latch the next digit into the drive word
    function automatic void drive_next();
        logic [7:0] segs;
        if (scan_ptr >= DIGITS)
            scan_ptr = '0;
        blink_count = blink_count + 8'd1;
        if (blink_count >= blink_period) begin
            for (int k = 0; k < DIGITS; k++)
                if (blink_en[k])
                    blink_dark[k] = !blink_dark[k];
            blink_count = '0;
        end
        segs = blink_dark[scan_ptr[IDX_W-1:0]] ? 8'h00 : pattern_mem[scan_ptr[IDX_W-1:0]];
        drive_word = {1'b1, scan_ptr, segs};
        scan_ptr = scan_ptr + 4'd1;
    endfunction

    function automatic void scan_tick();
        if (lit_ms != 16'hFFFF)
            lit_ms = lit_ms + 16'd1;
        if (lit_ms >= on_time) begin
            scan_state = PH_BLANK;
            drive_word = '0;
        end
        if (scan_state == PH_BLANK) begin
            scan_state = PH_DRIVE;
            lit_ms = '0;
        end else if (scan_state == PH_DRIVE) begin
            scan_state = PH_LIT;
            lit_ms = '0;
            drive_next();
        end
    endfunction

    function automatic logic [6:0] cap_99(input logic [6:0] v);
        return (v > 7'd99) ? 7'd99 : v;
    endfunction

    // Apply one command and return the drive state that follows it
    function automatic t_out_item update_display_model(input t_in_item c);
        t_out_item  r;
        logic [6:0] hh;
        logic [6:0] mm;
        logic [6:0] ss;
        logic [7:0] segs;
        case (c.opcode)
            OP_TICK: scan_tick();
            OP_RAW: begin
                if (c.digit_index < DIGITS)
                    pattern_mem[c.digit_index[IDX_W-1:0]] =
                        anode_mode ? ~c.value[7:0] : c.value[7:0];
            end
            OP_INT: load_decimal(c.value);
            OP_INT_DOT: begin
                if (c.dot_position != 0 && c.dot_position < DIGITS) begin
                    load_decimal(c.value);
                    pattern_mem[c.dot_position[IDX_W-1:0]] =
                        pattern_mem[c.dot_position[IDX_W-1:0]] | SEG_DOT;
                end
            end
            OP_TIME: begin
                hh = cap_99(c.hours);
                mm = cap_99(c.minutes);
                ss = cap_99(c.seconds);
                pattern_mem[0] = (hh / 10 == 0 && !full_hour) ?
                                 8'h00 : DIGIT_FONT[4'(hh / 10)];
                pattern_mem[1] = DIGIT_FONT[4'(hh % 10)];
                pattern_mem[2] = DIGIT_FONT[4'(mm / 10)];
                pattern_mem[3] = DIGIT_FONT[4'(mm % 10)];
                if (DIGITS >= 6) begin
                    pattern_mem[4 % DIGITS] = DIGIT_FONT[4'(ss / 10)];
                    pattern_mem[5 % DIGITS] = DIGIT_FONT[4'(ss % 10)];
                end
            end
            OP_BLINK_ON: begin
                if (c.digit_index < DIGITS) begin
                    blink_en[c.digit_index[IDX_W-1:0]]   = 1'b1;
                    blink_dark[c.digit_index[IDX_W-1:0]] = 1'b1;
                end
            end
            OP_BLINK_OFF: begin
                if (c.digit_index < DIGITS) begin
                    blink_en[c.digit_index[IDX_W-1:0]]   = 1'b0;
                    blink_dark[c.digit_index[IDX_W-1:0]] = 1'b0;
                end
            end
            default: ;
        endcase
        segs = drive_word[7:0];
        r.segment_lines = anode_mode ? ~segs : segs;
        r.digit_select  = drive_word[11:8];
        r.digit_active  = drive_word[12];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    function automatic int draw_gap();
        case (idle_mode)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // Offer one command, hold it until accepted, then record the prediction
    task automatic send_command(input t_in_item c);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= c;
        @(posedge i_clk);
        while (o_busy !== 1'b0)
            @(posedge i_clk);
        expected_drive_q.push_back(update_display_model(c));
    endtask

    function automatic t_in_item make_command(input logic [2:0] op, input logic [3:0] idx,
                                              input logic [31:0] v, input logic [3:0] dot,
                                              input logic [6:0] hh, input logic [6:0] mm,
                                              input logic [6:0] ss);
        t_in_item c;
        c.opcode       = op;
        c.digit_index  = idx;
        c.value        = v;
        c.dot_position = dot;
        c.hours        = hh;
        c.minutes      = mm;
        c.seconds      = ss;
        return c;
    endfunction

    task automatic send_tick();
        send_command(make_command(OP_TICK, 4'd0, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
    endtask

    // Mostly ticks, with well-formed commands and some out-of-range targets
    function automatic t_in_item random_command();
        t_in_item c;
        int r;
        c = {$urandom(), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 60) begin
            c.opcode = OP_TICK;
        end else if (r < 68) begin
            c.opcode = OP_RAW;
        end else if (r < 74) begin
            c.opcode = OP_INT;
            case ($urandom_range(0, 2))
                0: c.value = $urandom_range(0, 999);
                1: c.value = $urandom_range(0, 99999999);
                default: c.value = $urandom();
            endcase
        end else if (r < 78) begin
            c.opcode = OP_INT_DOT;
            if ($urandom_range(0, 4) != 0)
                c.dot_position = 4'($urandom_range(1, DIGITS - 1));
            if ($urandom_range(0, 1) == 0)
                c.value = $urandom_range(0, 99999);
        end else if (r < 84) begin
            c.opcode = OP_TIME;
            if ($urandom_range(0, 3) != 0) begin
                c.hours   = 7'($urandom_range(0, 23));
                c.minutes = 7'($urandom_range(0, 59));
                c.seconds = 7'($urandom_range(0, 59));
            end
        end else if (r < 91) begin
            c.opcode = OP_BLINK_ON;
        end else if (r < 97) begin
            c.opcode = OP_BLINK_OFF;
        end else begin
            c.opcode = OP_UNUSED;
        end
        if ($urandom_range(0, 9) != 0)
            c.digit_index = 4'($urandom_range(0, DIGITS - 1));
        return c;
    endfunction

    // Drop start and wait until the block is idle with nothing outstanding
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_drive_q.size() != 0 || o_busy !== 1'b0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COMMON_ANODE: anode_mode   = data[0];
            CFG_ON_TIME:      on_time      = data;
            CFG_BLINK_PERIOD: blink_period = data[7:0];
            CFG_FULL_HOUR:    full_hour    = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input bit anode, input logic [15:0] on_ms,
                                 input logic [7:0] period, input bit hour_zero);
        wait_for_idle();
        write_register(CFG_COMMON_ANODE, {15'd0, anode});
        write_register(CFG_ON_TIME, on_ms);
        write_register(CFG_BLINK_PERIOD, {8'd0, period});
        write_register(CFG_FULL_HOUR, {15'd0, hour_zero});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_items(input int count);
        repeat (count) send_command(random_command());
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR %0t ns: %s expected %02h got %02h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_drive_q.size() == 0) begin
                report_mismatch("result with no transaction pending", 8'h00, 8'h00);
            end else begin
                want = expected_drive_q.pop_front();
                if (o_result.segment_lines !== want.segment_lines)
                    report_mismatch("segment_lines", want.segment_lines,
                                    o_result.segment_lines);
                if (o_result.digit_select !== want.digit_select)
                    report_mismatch("digit_select", {4'd0, want.digit_select},
                                    {4'd0, o_result.digit_select});
                if (o_result.digit_active !== want.digit_active)
                    report_mismatch("digit_active", {7'd0, want.digit_active},
                                    {7'd0, o_result.digit_active});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults, field extremes, every command and the ignored cases
    task automatic test_directed_commands();
        idle_mode = 2;
        repeat (3) send_tick();
        send_command(make_command(OP_RAW, 4'd0, 32'hFFFF_FFFF, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_RAW, 4'(DIGITS - 1), 32'h0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_RAW, 4'(DIGITS), 32'hA5, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_RAW, 4'd15, 32'h5A, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT, 4'd0, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT, 4'd0, 32'hFFFF_FFFF, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT_DOT, 4'd0, 32'd12345678, 4'd1, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT_DOT, 4'd0, 32'd0, 4'(DIGITS - 1), 7'd0, 7'd0, 7'd0));
        // Dot on digit zero, just past the last digit and at the top code
        send_command(make_command(OP_INT_DOT, 4'd0, 32'd55, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT_DOT, 4'd0, 32'd55, 4'(DIGITS), 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_INT_DOT, 4'd0, 32'd55, 4'd15, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_TIME, 4'd0, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_TIME, 4'd0, 32'd0, 4'd0, 7'd127, 7'd127, 7'd127));
        send_command(make_command(OP_TIME, 4'd0, 32'd0, 4'd0, 7'd9, 7'd5, 7'd30));
        send_command(make_command(OP_BLINK_ON, 4'd0, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_BLINK_ON, 4'd15, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_BLINK_OFF, 4'(DIGITS), 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_BLINK_OFF, 4'd0, 32'd0, 4'd0, 7'd0, 7'd0, 7'd0));
        send_command(make_command(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 4'd15, 7'd127, 7'd127,
                                  7'd127));
        repeat (4) send_tick();
    endtask

    // Register extremes, including zero on-time and zero blink period
    task automatic test_setting_extremes();
        apply_setting(1'b0, 16'd2, 8'd100, 1'b0);
        idle_mode = 0;
        run_random_items(ITEMS_PER_PHASE);
        apply_setting(1'b1, 16'd1, 8'd1, 1'b1);
        idle_mode = 1;
        run_random_items(ITEMS_PER_PHASE);
        apply_setting(1'b0, 16'hFFFF, 8'hFF, 1'b0);
        idle_mode = 2;
        run_random_items(ITEMS_PER_PHASE);
        apply_setting(1'b1, 16'd0, 8'd0, 1'b1);
        idle_mode = 1;
        run_random_items(ITEMS_PER_PHASE);
        apply_setting(1'b0, 16'd3, 8'd2, 1'b1);
        idle_mode = 0;
        run_random_items(ITEMS_PER_PHASE);
    endtask

    // Random settings, mostly short on-times so the scan keeps moving
    task automatic test_random_settings();
        logic [15:0] on_ms;
        logic [7:0]  period;
        int          r;
        repeat (10) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                on_ms = 16'($urandom_range(1, 6));
            else if (r < 85)
                on_ms = 16'($urandom_range(0, 40));
            else
                on_ms = 16'($urandom());
            period = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 6))
                                                : 8'($urandom_range(0, 255));
            apply_setting(1'($urandom_range(0, 1)), on_ms, period, 1'($urandom_range(0, 1)));
            idle_mode = $urandom_range(0, 2);
            run_random_items(ITEMS_PER_PHASE);
        end
    endtask

    task automatic finish_run();
        int waited;
        @(negedge i_clk);
        i_start <= 1'b0;
        waited = 0;
        while (expected_drive_q.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_drive_q.size() != 0)
            report_mismatch("transactions left without a result",
                            8'(expected_drive_q.size()), 8'h00);
        if (mismatch_count == 0)
            $display("PASS seven_segment_scan_driver");
        else
            $display("FAIL seven_segment_scan_driver");
        $finish;
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_COMMON_ANODE;
        i_cfg_wdata    = '0;
        mismatch_count = 0;
        idle_mode      = 0;
        model_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_commands();
        test_setting_extremes();
        test_random_settings();
        finish_run();
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("FAIL seven_segment_scan_driver");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_ctrl.sv
sv/ssd_datapath.sv
sv/seven_segment_scan_driver.sv
verif/seven_segment_scan_driver_tb.sv
